// ===== rtl/core/meu_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
`default_nettype none

package meu_pkg;

   // Width of every payload and register field at the ports
   localparam int unsigned FIELD_WIDTH = 64;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] base_value;
      logic [FIELD_WIDTH-1:0] exponent;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] power_result;
      logic                   error_flag;
   } rsp_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE   = 7'b000_0001,
      S_REDUCE = 7'b000_0010,
      S_SCAN   = 7'b000_0100,
      S_DBL    = 7'b000_1000,
      S_ADD    = 7'b001_0000,
      S_MFIN   = 7'b010_0000,
      S_DONE   = 7'b100_0000
   } state_type;

endpackage : meu_pkg

`default_nettype wire

// ===== rtl/core/meu_addmod.sv =====
// Shared modular adder: (x + y + cin) mod m for operands below m.
`default_nettype none

module meu_addmod #(
   parameter int unsigned WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] x,
   input  wire logic [WIDTH-1:0] y,
   input  wire logic             cin,
   input  wire logic [WIDTH-1:0] m,
   output      logic [WIDTH-1:0] sum
);

   logic [WIDTH:0] raw_sum;
   logic [WIDTH:0] red_sum;
   logic           over;

   // Sum stays below 2m, so one conditional subtract reduces it
   always_comb begin
      raw_sum = {1'b0, x} + {1'b0, y} + {{WIDTH{1'b0}}, cin};
      red_sum = raw_sum - {1'b0, m};
      over    = (raw_sum >= {1'b0, m});
      sum     = over ? red_sum[WIDTH-1:0] : raw_sum[WIDTH-1:0];
   end

endmodule : meu_addmod

`default_nettype wire

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: base^exponent mod modulus, square-and-multiply.
//
// Usage: write the modulus on the csr_ channel (always ready) while the block
// is idle. Each transfer on the req_ channel carries a base and an exponent
// and gives exactly one transfer on the rsp_ channel with the power and an
// error flag (set, with a zero result, when the modulus is zero).
// One item is worked at a time; req_stall is high from acceptance until the
// result has been moved into the output register.
// A zero modulus or zero exponent goes straight to the done state. Otherwise
// the sequencer first reduces the base, then each scanned exponent bit costs
// a pass through the scan state, a squaring (none after the top bit) and,
// for a one bit, a multiplication. Every multiplication runs one double or
// add step per cycle through a single shared modular adder.
// The output register lets the next item be accepted while the last result
// waits; if the receiver stalls, a finished result holds in the sequencer
// until the output register is free.
// Reset (synchronous) clears the modulus to zero, empties the output and
// returns the sequencer to idle.
`default_nettype none

module modular_exponentiation_unit
   import meu_pkg::*;
#(
   parameter int unsigned OPERAND_WIDTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // item input
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_type                req_data,
   // result output
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_type                rsp_data,
   // modulus register write
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [FIELD_WIDTH-1:0] csr_data
);

   localparam int unsigned W      = OPERAND_WIDTH;
   localparam int unsigned CNT_W  = (W > 1) ? $clog2(W) : 1;
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(W - 1);

   state_type        state_ff, state_in;
   logic [W-1:0]     modulus_ff, modulus_in;
   logic [W-1:0]     mod_ff, mod_in;       // modulus latched for this item
   logic [W-1:0]     base_ff, base_in;
   logic [W-1:0]     exp_ff, exp_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     prod_ff, prod_in;
   logic [W-1:0]     cand_ff, cand_in;     // multiplicand added on one bits
   logic [W-1:0]     mlr_ff, mlr_in;       // multiplier, scanned from the top
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sqr_ff, sqr_in;       // current product is a squaring
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [W-1:0]     unit_y;
   logic             unit_cin;
   logic [W-1:0]     unit_sum;
   logic [W-1:0]     req_mod;
   logic [W-1:0]     req_base;
   logic [W-1:0]     req_exp;
   logic [W-1:0]     exp_next;
   logic             out_free;

   // Shared modular adder
   meu_addmod #(
      .WIDTH(W)
   ) u_addmod (
      .x   (prod_ff),
      .y   (unit_y),
      .cin (unit_cin),
      .m   (mod_ff),
      .sum (unit_sum)
   );

   assign unit_y   = (state_ff == S_ADD) ? cand_ff : prod_ff;
   assign unit_cin = (state_ff == S_REDUCE) ? base_ff[W-1] : 1'b0;

   assign req_mod  = modulus_ff;
   assign req_base = req_data.base_value[W-1:0];
   assign req_exp  = req_data.exponent[W-1:0];
   assign exp_next = exp_ff >> 1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      mod_in       = mod_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      cand_in      = cand_ff;
      mlr_in       = mlr_ff;
      cnt_in       = cnt_ff;
      sqr_in       = sqr_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         modulus_in = csr_data[W-1:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mod_in  = req_mod;
               base_in = req_base;
               exp_in  = req_exp;
               prod_in = '0;
               cnt_in  = CNT_TOP;
               err_in  = 1'b0;
               if (req_mod == '0) begin
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else if (req_exp == '0) begin
                  acc_in   = W'(1);
                  state_in = S_DONE;
               end else begin
                  state_in = S_REDUCE;
               end
            end
         end

         // Base mod modulus, one dividend bit a cycle
         S_REDUCE: begin
            prod_in = unit_sum;
            base_in = base_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               base_in  = unit_sum;
               acc_in   = (mod_ff == W'(1)) ? '0 : W'(1);
               state_in = S_SCAN;
            end
         end

         // Exponent bit: multiply into the accumulator, or go on to squaring
         S_SCAN: begin
            prod_in  = '0;
            cnt_in   = CNT_TOP;
            mlr_in   = base_ff;
            state_in = S_DBL;
            if (exp_ff[0]) begin
               cand_in = acc_ff;
               sqr_in  = 1'b0;
            end else begin
               cand_in = base_ff;
               sqr_in  = 1'b1;
               exp_in  = exp_next;
            end
         end

         // Product step: double
         S_DBL: begin
            prod_in = unit_sum;
            if (mlr_ff[W-1]) begin
               state_in = S_ADD;
            end else if (cnt_ff == '0) begin
               state_in = S_MFIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               mlr_in = mlr_ff << 1;
            end
         end

         // Product step: add multiplicand
         S_ADD: begin
            prod_in = unit_sum;
            if (cnt_ff == '0) begin
               state_in = S_MFIN;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               mlr_in   = mlr_ff << 1;
               state_in = S_DBL;
            end
         end

         // Product done: store it and pick the next operation
         S_MFIN: begin
            if (sqr_ff) begin
               base_in  = prod_ff;
               state_in = S_SCAN;
            end else begin
               acc_in = prod_ff;
               exp_in = exp_next;
               if (exp_next == '0) begin
                  state_in = S_DONE;
               end else begin
                  prod_in  = '0;
                  cnt_in   = CNT_TOP;
                  mlr_in   = base_ff;
                  cand_in  = base_ff;
                  sqr_in   = 1'b1;
                  state_in = S_DBL;
               end
            end
         end

         // Hand the result to the output register
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.power_result = FIELD_WIDTH'(acc_ff);
               rsp_data_in.error_flag   = err_ff;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mod_ff      <= mod_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      cand_ff     <= cand_in;
      mlr_ff      <= mlr_in;
      cnt_ff      <= cnt_in;
      sqr_ff      <= sqr_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : modular_exponentiation_unit

`default_nettype wire
